/* design/rejs_pkg.sv */
// Shared types and constants for the ML-KEM matrix rejection sampler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package rejs_pkg;

  // Coefficients per polynomial and largest matrix dimension.
  localparam int N_COEFFS = 256;
  localparam int K_MAX    = 4;

  // Coefficient counter must hold N_COEFFS itself.
  localparam int CNT_W   = $clog2(N_COEFFS + 1);
  localparam int IDX_W   = 8;
  localparam int COEF_W  = 12;
  localparam int POS_W   = 2;
  localparam int MOD_W   = 13;
  localparam int RANK_W  = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = MOD_W;

  // Result queue between the sampler and the output port.
  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [MOD_W-1:0]  MODULUS_RESET   = MOD_W'(3329);
  localparam logic [RANK_W-1:0] RANK_RESET      = RANK_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS   = 2'd0,
    REG_RANK      = 2'd1,
    REG_TRANSPOSE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PHASE_B0 = 2'd0,
    PHASE_B1 = 2'd1,
    PHASE_B2 = 2'd2
  } byte_phase_t;

  typedef struct packed {
    logic [MOD_W-1:0]  modulus;
    logic [RANK_W-1:0] matrix_rank;
    logic              transpose_mode;
  } cfg_t;

  typedef struct packed {
    logic [COEF_W-1:0] coefficient;
    logic [IDX_W-1:0]  coeff_index;
    logic [POS_W-1:0]  row_index;
    logic [POS_W-1:0]  col_index;
    logic [POS_W-1:0]  seed_byte_first;
    logic [POS_W-1:0]  seed_byte_second;
    logic              poly_last;
    logic              matrix_last;
  } result_t;

endpackage

/* design/rejs_sampler_core.sv */
// Byte grouping, candidate rejection and matrix position tracking.
// Depends on rejs_pkg; produces up to two compacted results per byte.
`timescale 1ns / 1ps

module rejs_sampler_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            xof_byte,
  input  logic                  stream_start,
  input  rejs_pkg::cfg_t        cfg,
  output rejs_pkg::result_t     res [2],
  output logic [1:0]            res_count
);
  import rejs_pkg::*;

  byte_phase_t        byte_phase, byte_phase_next;
  logic [7:0]         held_byte_zero, held_byte_zero_next;
  logic [7:0]         held_byte_one, held_byte_one_next;
  logic [CNT_W-1:0]   coeff_count, coeff_count_next;
  logic [POS_W-1:0]   row_pos, row_pos_next;
  logic [POS_W-1:0]   col_pos, col_pos_next;
  logic               poly_done, poly_done_next;

  logic               start;
  logic               active;
  logic               group;
  byte_phase_t        phase_eff;
  logic [CNT_W-1:0]   cnt_eff, cnt_mid;
  logic               done_eff, done_mid;
  logic [POS_W-1:0]   row_mid, col_mid, kmax_pos;
  logic [COEF_W-1:0]  d1, d2;
  logic               ok1, ok2, last1, last2;
  result_t            r1, r2;

  // Largest position index k-1, with rank 0 read as 1 and large ranks clamped.
  always_comb begin
    if (cfg.matrix_rank == '0) begin
      kmax_pos = '0;
    end else if (cfg.matrix_rank >= RANK_W'(K_MAX)) begin
      kmax_pos = POS_W'(K_MAX - 1);
    end else begin
      kmax_pos = POS_W'(cfg.matrix_rank - RANK_W'(1));
    end
  end

  function automatic result_t make_result(
    input logic [COEF_W-1:0] cand,
    input logic [CNT_W-1:0]  cnt,
    input logic [POS_W-1:0]  row,
    input logic [POS_W-1:0]  col,
    input logic [POS_W-1:0]  kpos,
    input logic              last,
    input logic              transp
  );
    result_t r;
    r.coefficient      = cand;
    r.coeff_index      = cnt[IDX_W-1:0];
    r.row_index        = row;
    r.col_index        = col;
    r.seed_byte_first  = transp ? row : col;
    r.seed_byte_second = transp ? col : row;
    r.poly_last        = last;
    r.matrix_last      = last && (row >= kpos) && (col >= kpos);
    return r;
  endfunction

  always_comb begin
    start     = fire && stream_start;
    phase_eff = start ? PHASE_B0 : byte_phase;
    cnt_eff   = start ? '0 : coeff_count;
    done_eff  = start ? 1'b0 : poly_done;
    active    = fire && !done_eff;
    group     = active && (phase_eff == PHASE_B2);

    d1 = {held_byte_one[3:0], held_byte_zero};
    d2 = {xof_byte, held_byte_one[7:4]};

    // First candidate.
    last1    = cnt_eff >= CNT_W'(N_COEFFS - 1);
    ok1      = group && ({1'b0, d1} < cfg.modulus);
    r1       = make_result(d1, cnt_eff, row_pos, col_pos, kmax_pos, last1,
                           cfg.transpose_mode);
    cnt_mid  = cnt_eff + CNT_W'(ok1);
    done_mid = done_eff || (ok1 && last1);
    row_mid  = row_pos;
    col_mid  = col_pos;
    if (ok1 && last1) begin
      if (col_pos >= kmax_pos) begin
        col_mid = '0;
        row_mid = (row_pos >= kmax_pos) ? '0 : row_pos + POS_W'(1);
      end else begin
        col_mid = col_pos + POS_W'(1);
      end
    end

    // Second candidate sees the state left by the first.
    last2 = cnt_mid >= CNT_W'(N_COEFFS - 1);
    ok2   = group && !done_mid && ({1'b0, d2} < cfg.modulus);
    r2    = make_result(d2, cnt_mid, row_mid, col_mid, kmax_pos, last2,
                        cfg.transpose_mode);

    coeff_count_next = cnt_mid + CNT_W'(ok2);
    poly_done_next   = done_mid || (ok2 && last2);
    row_pos_next     = row_mid;
    col_pos_next     = col_mid;
    if (ok2 && last2) begin
      if (col_mid >= kmax_pos) begin
        col_pos_next = '0;
        row_pos_next = (row_mid >= kmax_pos) ? '0 : row_mid + POS_W'(1);
      end else begin
        col_pos_next = col_mid + POS_W'(1);
      end
    end

    byte_phase_next     = byte_phase;
    held_byte_zero_next = held_byte_zero;
    held_byte_one_next  = held_byte_one;
    if (active) begin
      case (phase_eff)
        PHASE_B0: begin
          held_byte_zero_next = xof_byte;
          byte_phase_next     = PHASE_B1;
        end
        PHASE_B1: begin
          held_byte_one_next = xof_byte;
          byte_phase_next    = PHASE_B2;
        end
        default: begin
          byte_phase_next = PHASE_B0;
        end
      endcase
    end

    // Compact so that a lone accepted candidate is always in slot zero.
    res[0]    = ok1 ? r1 : r2;
    res[1]    = r2;
    res_count = {1'b0, ok1} + {1'b0, ok2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase     <= PHASE_B0;
      held_byte_zero <= '0;
      held_byte_one  <= '0;
      coeff_count    <= '0;
      row_pos        <= '0;
      col_pos        <= '0;
      poly_done      <= 1'b1;
    end else begin
      byte_phase     <= byte_phase_next;
      held_byte_zero <= held_byte_zero_next;
      held_byte_one  <= held_byte_one_next;
      coeff_count    <= coeff_count_next;
      row_pos        <= row_pos_next;
      col_pos        <= col_pos_next;
      poly_done      <= poly_done_next;
    end
  end

endmodule

/* design/rejs_result_fifo.sv */
// Small result queue: takes up to two results a cycle, gives one a beat.
// Depends on rejs_pkg for the result type and the queue depth.
`timescale 1ns / 1ps

module rejs_result_fifo (
  input  logic               clk,
  input  logic               rst,
  input  rejs_pkg::result_t  wr_data [2],
  input  logic [1:0]         wr_count,
  input  logic               rd_take,
  output logic               rd_valid,
  output rejs_pkg::result_t  rd_data,
  output logic               room_for_two
);
  import rejs_pkg::*;

  result_t             entries [FIFO_DEPTH];
  logic [FPTR_W-1:0]   head, tail;
  logic [FCNT_W-1:0]   fill, fill_next;
  logic                pop;

  assign rd_valid = (fill != '0);
  assign rd_data  = entries[head];
  assign pop      = rd_valid && rd_take;

  // Two free slots after this cycle's pop.
  assign room_for_two = (fill <= FCNT_W'(FIFO_DEPTH - 2)) ||
                        (pop && (fill == FCNT_W'(FIFO_DEPTH - 1)));

  assign fill_next = fill + FCNT_W'(wr_count) - FCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      entries[tail] <= wr_data[0];
    end
    if (wr_count == 2'd2) begin
      entries[tail + FPTR_W'(1)] <= wr_data[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head + FPTR_W'(pop);
      tail <= tail + FPTR_W'(wr_count);
      fill <= fill_next;
    end
  end

endmodule

/* design/mlkem_matrix_rejection_sampler_unit.sv */
// Top level of the ML-KEM matrix rejection sampler.
// Depends on rejs_pkg, rejs_sampler_core and rejs_result_fifo.
`timescale 1ns / 1ps

//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------------
//  in       | input     | in_valid / in_stall    | xof_byte, stream_start
//  out      | output    | out_valid / out_stall  | coefficient, coeff_index, row_index,
//           |           |                        | col_index, seed_byte_first,
//           |           |                        | seed_byte_second, poly_last,
//           |           |                        | matrix_last
//  cfg      | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One byte beat can be taken in every cycle in which the input does not stall.
// A byte is first captured in the input register; from there the sampler updates
// its state and writes zero, one or two results into a four-entry result queue,
// whose oldest entry drives the output combinationally. The output gives one
// result a beat, and the input stalls only when the queue cannot take two more
// results. Reset is synchronous and active high; after it the sampler ignores
// bytes until a beat with stream_start arrives.

module mlkem_matrix_rejection_sampler_unit (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   xof_byte,
  input  logic                         stream_start,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rejs_pkg::COEF_W-1:0]  coefficient,
  output logic [rejs_pkg::IDX_W-1:0]   coeff_index,
  output logic [rejs_pkg::POS_W-1:0]   row_index,
  output logic [rejs_pkg::POS_W-1:0]   col_index,
  output logic [rejs_pkg::POS_W-1:0]   seed_byte_first,
  output logic [rejs_pkg::POS_W-1:0]   seed_byte_second,
  output logic                         poly_last,
  output logic                         matrix_last,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rejs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rejs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rejs_pkg::*;

  cfg_t        cfg;
  logic        in_held;
  logic [7:0]  held_byte;
  logic        held_start;
  logic        room_for_two;
  logic        proc_fire;
  result_t     core_res [2];
  logic [1:0]  core_count;
  result_t     head;

  // Config writes always taken; user keeps block idle when they come; not enforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.modulus        <= MODULUS_RESET;
      cfg.matrix_rank    <= RANK_RESET;
      cfg.transpose_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULUS:   cfg.modulus        <= cfg_data;
        REG_RANK:      cfg.matrix_rank    <= cfg_data[RANK_W-1:0];
        REG_TRANSPOSE: cfg.transpose_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Input register. It drains whenever the queue has room for a full group,
  // so a byte that might yield two coefficients is never lost.
  assign proc_fire = in_held && room_for_two;
  assign in_stall  = in_held && !room_for_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (!in_stall) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held_byte  <= xof_byte;
      held_start <= stream_start;
    end
  end

  rejs_sampler_core u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (proc_fire),
    .xof_byte     (held_byte),
    .stream_start (held_start),
    .cfg          (cfg),
    .res          (core_res),
    .res_count    (core_count)
  );

  rejs_result_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .wr_data      (core_res),
    .wr_count     (core_count),
    .rd_take      (!out_stall),
    .rd_valid     (out_valid),
    .rd_data      (head),
    .room_for_two (room_for_two)
  );

  assign coefficient      = head.coefficient;
  assign coeff_index      = head.coeff_index;
  assign row_index        = head.row_index;
  assign col_index        = head.col_index;
  assign seed_byte_first  = head.seed_byte_first;
  assign seed_byte_second = head.seed_byte_second;
  assign poly_last        = head.poly_last;
  assign matrix_last      = head.matrix_last;

endmodule

/* tb/sv/tb_mlkem_matrix_rejection_sampler_unit.sv */
// Self-checking bench for the ML-KEM matrix rejection sampler top level.
// Depends on rejs_pkg and mlkem_matrix_rejection_sampler_unit; predicts every result
// from its own model of the sampler and checks it field by field.
`timescale 1ns / 1ps

module tb_mlkem_matrix_rejection_sampler_unit;
  import rejs_pkg::*;

  // Cycles the block may keep working after its last result: the input register,
  // the sampler stage and the result queue, plus some margin.
  localparam int DRAIN_CYCLES   = 6;
  // Cycles without any accepted beat on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 2000;
  // Mismatch reports are capped so that a broken block cannot flood the log.
  localparam int REPORT_CAP     = 40;

  // The predictor keeps its own copy of the registers and of the sampler state.
  // Every accepted byte beat is folded in and yields zero, one or two expected
  // coefficients, which wait in arrival order until the output side checks them.
  class coeff_scoreboard;
    logic [MOD_W-1:0]  modulus;
    logic [RANK_W-1:0] rank_reg;
    logic              transpose;

    byte_phase_t       phase;
    logic [7:0]        hold0;
    logic [7:0]        hold1;
    int unsigned       coeff_count;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    bit                done;

    result_t           expected_coeffs[$];
    int unsigned       errors;
    int unsigned       coeffs_seen;
    int unsigned       polys_seen;
    int unsigned       matrices_seen;

    function new();
      modulus       = MODULUS_RESET;
      rank_reg      = RANK_RESET;
      transpose     = 1'b0;
      phase         = PHASE_B0;
      hold0         = '0;
      hold1         = '0;
      coeff_count   = 0;
      row           = '0;
      col           = '0;
      done          = 1'b1;
      errors        = 0;
      coeffs_seen   = 0;
      polys_seen    = 0;
      matrices_seen = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_MODULUS:   modulus   = value[MOD_W-1:0];
        REG_RANK:      rank_reg  = value[RANK_W-1:0];
        REG_TRANSPOSE: transpose = value[0];
        default: ;
      endcase
    endfunction

    // Rank zero behaves as one and anything above the largest matrix as the largest.
    function int unsigned eff_rank();
      int unsigned k;
      k = rank_reg;
      if (k == 0) k = 1;
      if (k > K_MAX) k = K_MAX;
      return k;
    endfunction

    function void offer(logic [COEF_W-1:0] cand);
      int unsigned k;
      bit          last;
      result_t     r;
      if (done || cand >= modulus) return;
      k = eff_rank();
      last = (coeff_count + 1 >= N_COEFFS);
      r.coefficient      = cand;
      r.coeff_index      = coeff_count[IDX_W-1:0];
      r.row_index        = row;
      r.col_index        = col;
      r.seed_byte_first  = transpose ? row : col;
      r.seed_byte_second = transpose ? col : row;
      r.poly_last        = last;
      r.matrix_last      = last && (row + 1 >= k) && (col + 1 >= k);
      expected_coeffs.push_back(r);
      coeff_count = (coeff_count + 1) & 9'h1FF;
      if (last) begin
        // The polynomial is full; step to the next matrix position, row-major.
        done = 1'b1;
        if (col + 1 >= k) begin
          col = '0;
          row = (row + 1 >= k) ? '0 : row + 1'b1;
        end else begin
          col = col + 1'b1;
        end
      end
    endfunction

    function void take_xof_byte(logic [7:0] b, logic start);
      logic [COEF_W-1:0] d1;
      logic [COEF_W-1:0] d2;
      if (start) begin
        phase       = PHASE_B0;
        coeff_count = 0;
        done        = 1'b0;
      end else if (done) begin
        return;
      end
      case (phase)
        PHASE_B0: begin
          hold0 = b;
          phase = PHASE_B1;
        end
        PHASE_B1: begin
          hold1 = b;
          phase = PHASE_B2;
        end
        default: begin
          phase = PHASE_B0;
          d1 = {hold1[3:0], hold0};
          d2 = {b, hold1[7:4]};
          offer(d1);
          offer(d2);
        end
      endcase
    endfunction

    function bit poly_complete();
      return done;
    endfunction

    function int unsigned pending();
      return expected_coeffs.size();
    endfunction

    function void match_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_coeff(result_t got);
      result_t want;
      if (expected_coeffs.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: coefficient expected none, got %0d at index %0d",
                   $time, got.coefficient, got.coeff_index);
        return;
      end
      want = expected_coeffs.pop_front();
      match_field("coefficient", want.coefficient, got.coefficient);
      match_field("coeff_index", want.coeff_index, got.coeff_index);
      match_field("row_index", want.row_index, got.row_index);
      match_field("col_index", want.col_index, got.col_index);
      match_field("seed_byte_first", want.seed_byte_first, got.seed_byte_first);
      match_field("seed_byte_second", want.seed_byte_second, got.seed_byte_second);
      match_field("poly_last", want.poly_last, got.poly_last);
      match_field("matrix_last", want.matrix_last, got.matrix_last);
      coeffs_seen++;
      if (got.poly_last) polys_seen++;
      if (got.matrix_last) matrices_seen++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            xof_byte = '0;
  logic                  stream_start = 1'b0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COEF_W-1:0]     coefficient;
  logic [IDX_W-1:0]      coeff_index;
  logic [POS_W-1:0]      row_index;
  logic [POS_W-1:0]      col_index;
  logic [POS_W-1:0]      seed_byte_first;
  logic [POS_W-1:0]      seed_byte_second;
  logic                  poly_last;
  logic                  matrix_last;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  coeff_scoreboard sb = new();

  // Set for the closing part of the run, where neither side idles any more.
  bit          quiet_tail = 1'b0;
  int unsigned bytes_in = 0;
  int unsigned out_hold_left = 0;
  int unsigned idle_cycles = 0;

  mlkem_matrix_rejection_sampler_unit dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .xof_byte         (xof_byte),
    .stream_start     (stream_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .coefficient      (coefficient),
    .coeff_index      (coeff_index),
    .row_index        (row_index),
    .col_index        (col_index),
    .seed_byte_first  (seed_byte_first),
    .seed_byte_second (seed_byte_second),
    .poly_last        (poly_last),
    .matrix_last      (matrix_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Output side. Every beat that the block hands over is checked against the
  // oldest expected coefficient. Signals are sampled at the rising edge, before
  // any register of the block or the bench has moved.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_coeff({coefficient, coeff_index, row_index, col_index,
                      seed_byte_first, seed_byte_second, poly_last, matrix_last});
  end

  // Receiver back-pressure comes in bursts, started at random,
  // and is switched off for the closing part of the run.
  always @(posedge clk) begin
    if (rst || quiet_tail) begin
      out_stall     <= 1'b0;
      out_hold_left <= 0;
    end else if (out_hold_left != 0) begin
      out_stall     <= 1'b1;
      out_hold_left <= out_hold_left - 1;
    end else if ($urandom_range(0, 19) == 0) begin
      out_stall     <= 1'b1;
      out_hold_left <= $urandom_range(0, 11);
    end else begin
      out_stall     <= 1'b0;
    end
  end

  // Count cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAIL mlkem_matrix_rejection_sampler_unit");
    $finish;
  end

  // Drop the input valid for a burst of cycles. The previous beat has already
  // been taken, so nothing is left half-presented.
  task automatic pause_input(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Present one byte beat and hold it until the block takes it. Valid stays
  // high afterwards so that back-to-back beats do not toggle it; the next beat
  // or a pause decides what happens to it.
  task automatic push_byte(input logic [7:0] b, input logic start);
    if (!quiet_tail && $urandom_range(0, 15) == 0)
      pause_input($urandom_range(1, 12));
    in_valid     <= 1'b1;
    xof_byte     <= b;
    stream_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_xof_byte(b, start);
    bytes_in++;
  endtask

  // Let every expected coefficient come out, then give the block the time
  // it may still need for bytes that produce no result. Registers are only
  // written once this has returned.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg_beat(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  // All three registers are written back to back; valid drops after the last.
  task automatic set_config(input logic [MOD_W-1:0] q, input logic [RANK_W-1:0] k,
                            input logic t);
    write_reg_beat(REG_MODULUS, q);
    write_reg_beat(REG_RANK, CFG_DATA_W'(k));
    write_reg_beat(REG_TRANSPOSE, CFG_DATA_W'(t));
    cfg_valid <= 1'b0;
  endtask

  // One well-formed polynomial stream: a start beat, random bytes until the
  // predictor sees the polynomial full, once in a while a restart in the middle,
  // and a few trailing bytes that the block has to ignore.
  task automatic feed_poly();
    push_byte(8'($urandom_range(0, 255)), 1'b1);
    while (!sb.poly_complete()) begin
      if ($urandom_range(0, 4999) == 0)
        push_byte(8'($urandom_range(0, 255)), 1'b1);
      else
        push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Loose traffic: stream starts at random points, so groups are cut short,
  // with zero bytes mixed in so that a tiny modulus still accepts something.
  task automatic feed_noise(input int unsigned count, input int unsigned zero_pct);
    logic [7:0] b;
    repeat (count) begin
      b = ($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom_range(0, 255));
      push_byte(b, $urandom_range(0, 7) == 0);
    end
  endtask

  // Directed opening under the reset settings (modulus 3329, rank 3, origin order).
  task automatic directed_bytes();
    // Nothing has started yet, so these two beats must be ignored.
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    // All-zero group: two zero coefficients.
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    // All-ones group: both candidates are 4095 and rejected.
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    // First candidate one below the modulus, second exactly on it.
    push_byte(8'h00, 1'b0);
    push_byte(8'h1D, 1'b0);
    push_byte(8'hD0, 1'b0);
    // The other way round: first on the modulus, second just below.
    push_byte(8'h01, 1'b0);
    push_byte(8'h0D, 1'b0);
    push_byte(8'hD0, 1'b0);
    // A group cut short by a new stream start, which also clears the count.
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h12, 1'b1);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    // Alternating bit patterns.
    push_byte(8'h5A, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h3C, 1'b0);
  endtask

  // Phase plan. Rank changes happen in mid-matrix on purpose, so positions
  // beyond the new rank have to wrap at the next advance:
  //   modulus 8191, rank 4, transposed: one polynomial, position goes to (0,1).
  //   modulus 4096, rank 2, origin:     column 1 wraps, position goes to (1,0).
  //   modulus 3329, rank 7 (as 4):      one polynomial, ends at (1,1).
  //   modulus 0, rank 0:                nothing can be accepted.
  //   modulus 1, rank 5 (as 4):         only zero candidates pass.
  //   modulus 4096, rank 0 (as 1):      (1,1) is beyond the rank, so this
  //                                     polynomial closes the matrix and wraps.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    directed_bytes();

    drain_block();
    set_config(13'd8191, 3'd4, 1'b1);
    feed_poly();

    drain_block();
    set_config(13'd4096, 3'd2, 1'b0);
    feed_poly();

    drain_block();
    set_config(13'd3329, 3'd7, 1'b1);
    feed_poly();

    drain_block();
    set_config(13'd0, 3'd0, 1'b0);
    feed_noise(40, 25);

    drain_block();
    set_config(13'd1, 3'd5, 1'b1);
    feed_noise(60, 60);

    // Closing part: no idling on either side from here on.
    drain_block();
    quiet_tail = 1'b1;
    set_config(13'd4096, 3'd0, 1'b0);
    feed_poly();

    drain_block();
    repeat (4 * DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d XOF bytes; checked %0d coefficients over %0d polynomials",
             bytes_in, sb.coeffs_seen, sb.polys_seen);
    $display("Completed %0d matrices across seven register settings, %0d field mismatches",
             sb.matrices_seen, sb.errors);
    if (sb.errors == 0)
      $display("PASS mlkem_matrix_rejection_sampler_unit");
    else
      $display("FAIL mlkem_matrix_rejection_sampler_unit");
    $finish;
  end

endmodule

/* sim.f */
design/rejs_pkg.sv
design/rejs_sampler_core.sv
design/rejs_result_fifo.sv
design/mlkem_matrix_rejection_sampler_unit.sv
tb/sv/tb_mlkem_matrix_rejection_sampler_unit.sv
